// ===== hw/rtl/dwsp_pkg.sv =====
package dwsp_pkg;

   // fixed-point position of speeds, errors, integrals and accumulators
   localparam int FRAC_BITS = 16;
   // distance_per_count carries 24 fraction bits
   localparam int DEN_SHIFT = 24 - FRAC_BITS;
   // gains are Q8.8
   localparam int GAIN_FRAC = 8;

   localparam int TICK_W = 20;
   localparam int SPD_W  = 32;
   localparam int ERR_W  = 32;
   localparam int INT_W  = 23;
   localparam int TGT_W  = 34;
   localparam int DRV_W  = 11;
   localparam int ACC_W  = 10 + FRAC_BITS + 1;
   localparam int SUM_W  = 52;

   // shared multiplier operands
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 21;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // speed numerator count * distance * 1e6, then the divider
   localparam int NUM_W = 53;
   localparam int DVD_W = NUM_W - DEN_SHIFT;
   localparam int QUO_W = 32;
   localparam int HI_W  = DVD_W - QUO_W;
   localparam int CMP_W = ((HI_W > TICK_W) ? HI_W : TICK_W) + 1;
   localparam int CNT_W = $clog2(QUO_W);

   localparam logic signed [MUL_B_W-1:0] US_PER_S = MUL_B_W'(1000000);
   localparam logic signed [SPD_W-1:0]   SPD_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [SPD_W-1:0]   SPD_MIN  = 32'sh8000_0000;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 22;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P,
      CSR_GAIN_D,
      CSR_GAIN_I,
      CSR_INTEGRAL_LIMIT,
      CSR_INTEGRAL_DEADBAND,
      CSR_DRIVE_LIMIT,
      CSR_DISTANCE_PER_COUNT,
      CSR_HALF_TRACK
   } csr_index_type;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_d;
      logic [15:0] gain_i;
      logic [21:0] integral_limit;
      logic [21:0] integral_deadband;
      logic [9:0]  drive_limit;
      logic [15:0] distance_per_count;
      logic [17:0] half_track;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TURN_MUL,
      ST_TURN_ADD,
      ST_MAG_MUL,
      ST_SCALE_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ERR,
      ST_P_MUL,
      ST_D_MUL,
      ST_I_MUL,
      ST_I_ADD,
      ST_ACC_ADD,
      ST_ACC_SAT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [TICK_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             ovf;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hw/rtl/dwsp_req_if.sv =====
interface dwsp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_count;
   logic signed [15:0] right_count;
   logic        [19:0] tick_us;
   logic signed [20:0] target_linear;
   logic signed [21:0] target_angular;

   modport source (
      output valid, left_count, right_count, tick_us, target_linear, target_angular,
      input  ready
   );
   modport sink (
      input  valid, left_count, right_count, tick_us, target_linear, target_angular,
      output ready
   );
endinterface

// ===== hw/rtl/dwsp_rsp_if.sv =====
interface dwsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [10:0] left_drive;
   logic signed [10:0] right_drive;
   logic signed [31:0] left_speed;
   logic signed [31:0] right_speed;

   modport source (
      output valid, left_drive, right_drive, left_speed, right_speed,
      input  ready
   );
   modport sink (
      input  valid, left_drive, right_drive, left_speed, right_speed,
      output ready
   );
endinterface

// ===== hw/rtl/dwsp_csr.sv =====
module dwsp_csr import dwsp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   localparam cfg_type CFG_RESET = '{
      gain_p:             16'd8960,
      gain_d:             16'd1792,
      gain_i:             16'd294,
      integral_limit:     22'd458752,
      integral_deadband:  22'd9830,
      drive_limit:        10'd400,
      distance_per_count: 16'd8429,
      half_track:         18'd18678
   };

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:             cfg_in.gain_p             = csr_wdata[15:0];
            CSR_GAIN_D:             cfg_in.gain_d             = csr_wdata[15:0];
            CSR_GAIN_I:             cfg_in.gain_i             = csr_wdata[15:0];
            CSR_INTEGRAL_LIMIT:     cfg_in.integral_limit     = csr_wdata[21:0];
            CSR_INTEGRAL_DEADBAND:  cfg_in.integral_deadband  = csr_wdata[21:0];
            CSR_DRIVE_LIMIT:        cfg_in.drive_limit        = csr_wdata[9:0];
            CSR_DISTANCE_PER_COUNT: cfg_in.distance_per_count = csr_wdata[15:0];
            CSR_HALF_TRACK:         cfg_in.half_track         = csr_wdata[17:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/dwsp_mul.sv =====
module dwsp_mul import dwsp_pkg::*; (
   input  logic                       clock,
   input  logic signed [MUL_A_W-1:0]  mul_a,
   input  logic signed [MUL_B_W-1:0]  mul_b,
   output logic signed [MUL_P_W-1:0]  prod
);

   logic signed [MUL_P_W-1:0] prod_ff, prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/dwsp_div.sv =====
module dwsp_div import dwsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TICK_W-1:0] rem_ff, rem_in;
   logic [TICK_W-1:0] dsr_ff, dsr_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;

   logic [HI_W-1:0]   hi;
   logic              hi_ovf;
   logic [TICK_W:0]   shifted;
   logic [TICK_W:0]   trial;

   // upper dividend bits at or above the divisor mean a quotient of 2^32 or more
   assign hi      = req.dividend[DVD_W-1:QUO_W];
   assign hi_ovf  = CMP_W'(hi) >= CMP_W'(req.divisor);
   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         dsr_in  = req.divisor;
         cnt_in  = '0;
         quo_in  = req.dividend[QUO_W-1:0];
         rem_in  = TICK_W'(hi);
         ovf_in  = hi_ovf;
         busy_in = !hi_ovf;
         done_in = hi_ovf;
      end else if (busy_ff) begin
         // restoring step, one quotient bit a cycle
         if (!trial[TICK_W]) begin
            rem_in = trial[TICK_W-1:0];
         end else begin
            rem_in = shifted[TICK_W-1:0];
         end
         quo_in = {quo_ff[QUO_W-2:0], !trial[TICK_W]};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.ovf      = ovf_ff;
   assign rsp.quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_cause: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) || $past(req.start)))
      else $error("divider done without a division in progress");

endmodule

// ===== hw/rtl/dual_wheel_speed_pid.sv =====
// channel  | direction | transaction carries
// req_bus  | in        | left_count, right_count, tick_us, target_linear, target_angular
// rsp_bus  | out       | left_drive, right_drive, left_speed, right_speed
// csr_*    | in        | register write, index 0..7, no read-back
//
// one transaction at a time: req_bus is ready only while the controller is idle
// a wheel speed whose quotient reaches 2^32 skips the divider's bit-serial steps
// the bit-serial divider computes each wheel speed in turn, left then right
// all multiplication goes through one registered 34x21 multiplier
// reset is synchronous and clears the controller state to zero, registers to defaults
// a transaction is taken while a result waits on rsp_bus; it then holds in its last step
module dual_wheel_speed_pid import dwsp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   dwsp_req_if.sink               req_bus,
   dwsp_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ERR_CALC_W = TGT_W + 2;
   localparam int INT_CALC_W = ERR_W + 2;
   localparam logic [MUL_P_W-1:0] TURN_RND = MUL_P_W'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic [SUM_W-1:0]   SUM_RND  = SUM_W'((64'd1 << GAIN_FRAC) - 64'd1);
   localparam logic [ACC_W-1:0]   ACC_RND  = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

   function automatic logic signed [DRV_W-1:0] acc_to_drive(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] rnd;
      rnd = acc + $signed(acc[ACC_W-1] ? ACC_RND : '0);
      return DRV_W'(rnd >>> FRAC_BITS);
   endfunction

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   state_type state_ff, state_in;
   logic      side_ff, side_in;

   logic signed [15:0]       lc_ff, lc_in, rc_ff, rc_in;
   logic        [TICK_W-1:0] tick_ff, tick_in;
   logic signed [20:0]       v_ff, v_in;
   logic signed [21:0]       w_ff, w_in;

   logic signed [TGT_W-1:0] tl_ff, tl_in, tr_ff, tr_in;
   logic signed [SPD_W-1:0] sl_ff, sl_in, sr_ff, sr_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] work_ff, work_in;

   logic signed [ACC_W-1:0] acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic signed [INT_W-1:0] int_l_ff, int_l_in, int_r_ff, int_r_in;
   logic signed [ERR_W-1:0] last_l_ff, last_l_in, last_r_ff, last_r_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DRV_W-1:0] ldrv_ff, ldrv_in, rdrv_ff, rdrv_in;
   logic signed [SPD_W-1:0] lspd_ff, lspd_in, rspd_ff, rspd_in;

   // per-wheel selection
   logic signed [15:0]       cur_cnt;
   logic signed [16:0]       cnt_ext;
   logic        [16:0]       mag;
   logic signed [TGT_W-1:0]  tgt_cur;
   logic signed [SPD_W-1:0]  spd_cur;
   logic signed [INT_W-1:0]  int_cur;
   logic signed [ERR_W-1:0]  last_cur;
   logic signed [ACC_W-1:0]  acc_cur;

   logic signed [MUL_P_W-1:0]    turn_sum;
   logic signed [MUL_P_W-1:0]    turn_full;
   logic signed [TGT_W-1:0]      turn;
   logic        [QUO_W-1:0]      quo;
   logic signed [SPD_W-1:0]      spd_new;
   logic signed [ERR_CALC_W-1:0] diff;
   logic signed [ERR_W-1:0]      err_sat;
   logic signed [INT_CALC_W-1:0] isum, ilim, idb, iclamp;
   logic signed [INT_W-1:0]      int_new;
   logic signed [MUL_A_W-1:0]    d_op;
   logic signed [SUM_W-1:0]      sum_rnd, sum_q, acc_sum, dlim, acc_clamp;
   logic                         accept;

   dwsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dwsp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (mul_p)
   );

   dwsp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept = req_bus.valid && req_bus.ready;

   assign cur_cnt  = side_ff ? rc_ff : lc_ff;
   assign cnt_ext  = 17'(cur_cnt);
   assign mag      = cnt_ext[16] ? 17'(-cnt_ext) : 17'(cnt_ext);
   assign tgt_cur  = side_ff ? tr_ff : tl_ff;
   assign spd_cur  = side_ff ? sr_ff : sl_ff;
   assign int_cur  = side_ff ? int_r_ff : int_l_ff;
   assign last_cur = side_ff ? last_r_ff : last_l_ff;
   assign acc_cur  = side_ff ? acc_r_ff : acc_l_ff;

   // w * half_track, divided toward zero
   assign turn_sum  = mul_p + $signed(mul_p[MUL_P_W-1] ? TURN_RND : '0);
   assign turn_full = turn_sum >>> FRAC_BITS;
   assign turn      = TGT_W'(turn_full);

   // divider quotient to a signed, saturated speed
   assign quo = div_rsp.quotient;
   always_comb begin
      if (cur_cnt[15]) begin
         if (div_rsp.ovf || (quo > 32'h8000_0000)) begin
            spd_new = SPD_MIN;
         end else begin
            spd_new = $signed(32'd0 - quo);
         end
      end else begin
         if (div_rsp.ovf || quo[QUO_W-1]) begin
            spd_new = SPD_MAX;
         end else begin
            spd_new = $signed(quo);
         end
      end
   end

   assign diff = ERR_CALC_W'(tgt_cur) - ERR_CALC_W'(spd_cur);
   always_comb begin
      if (diff > ERR_CALC_W'(SPD_MAX)) begin
         err_sat = SPD_MAX;
      end else if (diff < ERR_CALC_W'(SPD_MIN)) begin
         err_sat = SPD_MIN;
      end else begin
         err_sat = ERR_W'(diff);
      end
   end

   // integral: add, clamp, then deadband
   assign isum = INT_CALC_W'(int_cur) + INT_CALC_W'(err_ff);
   assign ilim = $signed(INT_CALC_W'(cfg.integral_limit));
   assign idb  = $signed(INT_CALC_W'(cfg.integral_deadband));
   always_comb begin
      if (isum > ilim) begin
         iclamp = ilim;
      end else if (isum < -ilim) begin
         iclamp = -ilim;
      end else begin
         iclamp = isum;
      end
      if ((iclamp < idb) && (iclamp > -idb)) begin
         int_new = '0;
      end else begin
         int_new = INT_W'(iclamp);
      end
   end

   assign d_op = MUL_A_W'(err_ff) - MUL_A_W'(last_cur);

   // drive update: sum / 256 toward zero, add to the accumulator, then saturate
   assign sum_rnd = sum_ff + $signed(sum_ff[SUM_W-1] ? SUM_RND : '0);
   assign sum_q   = sum_rnd >>> GAIN_FRAC;
   assign acc_sum = SUM_W'(acc_cur) + sum_q;
   assign dlim    = $signed(SUM_W'({cfg.drive_limit, {FRAC_BITS{1'b0}}}));
   always_comb begin
      if (work_ff > dlim) begin
         acc_clamp = dlim;
      end else if (work_ff < -dlim) begin
         acc_clamp = -dlim;
      end else begin
         acc_clamp = work_ff;
      end
   end

   assign div_req.start    = (state_ff == ST_DIV_START);
   assign div_req.dividend = mul_p[NUM_W-1:DEN_SHIFT];
   assign div_req.divisor  = tick_ff;

   always_comb begin
      state_in  = state_ff;
      side_in   = side_ff;
      lc_in     = lc_ff;
      rc_in     = rc_ff;
      tick_in   = tick_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      tl_in     = tl_ff;
      tr_in     = tr_ff;
      sl_in     = sl_ff;
      sr_in     = sr_ff;
      err_in    = err_ff;
      sum_in    = sum_ff;
      work_in   = work_ff;
      acc_l_in  = acc_l_ff;
      acc_r_in  = acc_r_ff;
      int_l_in  = int_l_ff;
      int_r_in  = int_r_ff;
      last_l_in = last_l_ff;
      last_r_in = last_r_ff;
      ldrv_in   = ldrv_ff;
      rdrv_in   = rdrv_ff;
      lspd_in   = lspd_ff;
      rspd_in   = rspd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mul_a     = '0;
      mul_b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lc_in    = req_bus.left_count;
               rc_in    = req_bus.right_count;
               // a zero tick counts as one microsecond
               tick_in  = (req_bus.tick_us == '0) ? TICK_W'(1) : req_bus.tick_us;
               v_in     = req_bus.target_linear;
               w_in     = req_bus.target_angular;
               side_in  = 1'b0;
               state_in = ST_TURN_MUL;
            end
         end
         ST_TURN_MUL: begin
            mul_a    = MUL_A_W'(w_ff);
            mul_b    = $signed(MUL_B_W'(cfg.half_track));
            state_in = ST_TURN_ADD;
         end
         ST_TURN_ADD: begin
            tl_in    = TGT_W'(v_ff) - turn;
            tr_in    = TGT_W'(v_ff) + turn;
            state_in = ST_MAG_MUL;
         end
         ST_MAG_MUL: begin
            mul_a    = $signed(MUL_A_W'(mag));
            mul_b    = $signed(MUL_B_W'(cfg.distance_per_count));
            state_in = ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            mul_a    = $signed(mul_p[MUL_A_W-1:0]);
            mul_b    = US_PER_S;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (side_ff) begin
                  sr_in    = spd_new;
                  side_in  = 1'b0;
                  state_in = ST_ERR;
               end else begin
                  sl_in    = spd_new;
                  side_in  = 1'b1;
                  state_in = ST_MAG_MUL;
               end
            end
         end
         ST_ERR: begin
            err_in   = err_sat;
            state_in = ST_P_MUL;
         end
         ST_P_MUL: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed(MUL_B_W'(cfg.gain_p));
            if (side_ff) begin
               int_r_in = int_new;
            end else begin
               int_l_in = int_new;
            end
            state_in = ST_D_MUL;
         end
         ST_D_MUL: begin
            sum_in = SUM_W'(mul_p);
            mul_a  = d_op;
            mul_b  = $signed(MUL_B_W'(cfg.gain_d));
            if (side_ff) begin
               last_r_in = err_ff;
            end else begin
               last_l_in = err_ff;
            end
            state_in = ST_I_MUL;
         end
         ST_I_MUL: begin
            sum_in   = sum_ff + SUM_W'(mul_p);
            mul_a    = MUL_A_W'(int_cur);
            mul_b    = $signed(MUL_B_W'(cfg.gain_i));
            state_in = ST_I_ADD;
         end
         ST_I_ADD: begin
            sum_in   = sum_ff + SUM_W'(mul_p);
            state_in = ST_ACC_ADD;
         end
         ST_ACC_ADD: begin
            work_in  = acc_sum;
            state_in = ST_ACC_SAT;
         end
         ST_ACC_SAT: begin
            if (side_ff) begin
               acc_r_in = ACC_W'(acc_clamp);
               side_in  = 1'b0;
               state_in = ST_OUT;
            end else begin
               acc_l_in = ACC_W'(acc_clamp);
               side_in  = 1'b1;
               state_in = ST_ERR;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               ldrv_in      = acc_to_drive(acc_l_ff);
               rdrv_in      = acc_to_drive(acc_r_ff);
               lspd_in      = sl_ff;
               rspd_in      = sr_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_l_ff     <= '0;
         acc_r_ff     <= '0;
         int_l_ff     <= '0;
         int_r_ff     <= '0;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_l_ff     <= acc_l_in;
         acc_r_ff     <= acc_r_in;
         int_l_ff     <= int_l_in;
         int_r_ff     <= int_r_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
      end
   end

   always_ff @(posedge clock) begin
      lc_ff   <= lc_in;
      rc_ff   <= rc_in;
      tick_ff <= tick_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      tl_ff   <= tl_in;
      tr_ff   <= tr_in;
      sl_ff   <= sl_in;
      sr_ff   <= sr_in;
      err_ff  <= err_in;
      sum_ff  <= sum_in;
      work_ff <= work_in;
      ldrv_ff <= ldrv_in;
      rdrv_ff <= rdrv_in;
      lspd_ff <= lspd_in;
      rspd_ff <= rspd_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_drive  = ldrv_ff;
   assign rsp_bus.right_drive = rdrv_ff;
   assign rsp_bus.left_speed  = lspd_ff;
   assign rsp_bus.right_speed = rspd_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_TURN_MUL))
      else $error("accepted transaction did not start the sequence");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_right_speed_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT && div_rsp.done && side_ff)
         |=> (state_ff == ST_ERR && !side_ff))
      else $error("controller did not start with the left wheel after both speeds");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import dwsp_pkg::*;

   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int DRAIN_CYCLES     = 100;
   localparam int RANDOM_PER_PHASE = 215;
   localparam int PHASE_COUNT      = 9;
   localparam int REPORT_CAP       = 40;

   localparam longint S32_MAX = 64'sh7FFF_FFFF;
   localparam longint S32_MIN = -64'sh8000_0000;

   localparam cfg_type DEFAULT_CFG = '{
      gain_p: 16'd8960, gain_d: 16'd1792, gain_i: 16'd294,
      integral_limit: 22'd458752, integral_deadband: 22'd9830,
      drive_limit: 10'd400, distance_per_count: 16'd8429, half_track: 18'd18678
   };
   localparam cfg_type MAX_CFG = '{
      gain_p: 16'hFFFF, gain_d: 16'hFFFF, gain_i: 16'hFFFF,
      integral_limit: 22'd2097152, integral_deadband: 22'd2097152,
      drive_limit: 10'd1023, distance_per_count: 16'hFFFF, half_track: 18'd131072
   };

   typedef struct {
      logic signed [15:0] left_count;
      logic signed [15:0] right_count;
      logic        [19:0] tick_us;
      logic signed [20:0] target_linear;
      logic signed [21:0] target_angular;
   } wheel_cmd_type;

   typedef struct {
      logic signed [10:0] left_drive;
      logic signed [10:0] right_drive;
      logic signed [31:0] left_speed;
      logic signed [31:0] right_speed;
   } drive_out_type;

   class drive_scoreboard;
      longint gain_p, gain_d, gain_i;
      longint integ_lim, integ_db, drv_lim, dist_per_count, half_span;
      longint acc[2];
      longint integ[2];
      longint last_err[2];
      drive_out_type expected_drives[$];
      string faults[$];

      function new();
         gain_p = 8960;
         gain_d = 1792;
         gain_i = 294;
         integ_lim = 458752;
         integ_db = 9830;
         drv_lim = 400;
         dist_per_count = 8429;
         half_span = 18678;
         for (int w = 0; w < 2; w++) begin
            acc[w] = 0;
            integ[w] = 0;
            last_err[w] = 0;
         end
      endfunction

      function void set_register(csr_index_type idx, longint value);
         case (idx)
            CSR_GAIN_P:             gain_p = value & 'hFFFF;
            CSR_GAIN_D:             gain_d = value & 'hFFFF;
            CSR_GAIN_I:             gain_i = value & 'hFFFF;
            CSR_INTEGRAL_LIMIT:     integ_lim = value & 'h3F_FFFF;
            CSR_INTEGRAL_DEADBAND:  integ_db = value & 'h3F_FFFF;
            CSR_DRIVE_LIMIT:        drv_lim = value & 'h3FF;
            CSR_DISTANCE_PER_COUNT: dist_per_count = value & 'hFFFF;
            CSR_HALF_TRACK:         half_span = value & 'h3_FFFF;
            default: ;
         endcase
      endfunction

      function longint clip32(longint x);
         if (x > S32_MAX) return S32_MAX;
         if (x < S32_MIN) return S32_MIN;
         return x;
      endfunction

      function longint measured_speed(longint count, longint tick);
         longint unsigned mag, num, den, q;
         mag = (count < 0) ? -count : count;
         num = mag * longint'(dist_per_count) * 64'd1000000;
         // zero tick length counts as one microsecond
         den = longint'((tick == 0) ? 1 : tick) << DEN_SHIFT;
         q = num / den;
         if (count < 0) begin
            if (q > 64'h8000_0000) return S32_MIN;
            return -longint'(q);
         end
         if (q > 64'h7FFF_FFFF) return S32_MAX;
         return longint'(q);
      endfunction

      function longint pid_step(longint target, longint speed, int w);
         longint err, i, total, lim;
         err = clip32(target - speed);
         i = integ[w] + err;
         // clamp first, deadband after, so a deadband above the limit zeroes it
         if (i > integ_lim) i = integ_lim;
         if (i < -integ_lim) i = -integ_lim;
         if (i < integ_db && i > -integ_db) i = 0;
         integ[w] = i;
         total = gain_p * err + gain_d * (err - last_err[w]) + gain_i * i;
         last_err[w] = err;
         lim = drv_lim * (64'sd1 <<< FRAC_BITS);
         acc[w] += total / 256;
         if (acc[w] > lim) acc[w] = lim;
         if (acc[w] < -lim) acc[w] = -lim;
         return acc[w] / (64'sd1 <<< FRAC_BITS);
      endfunction

      function void note_command(wheel_cmd_type c);
         longint v, w, turn, sl, sr;
         drive_out_type want;
         v = c.target_linear;
         w = c.target_angular;
         turn = (w * half_span) / (64'sd1 <<< FRAC_BITS);
         sl = measured_speed(c.left_count, c.tick_us);
         sr = measured_speed(c.right_count, c.tick_us);
         want.left_drive = 11'(pid_step(v - turn, sl, 0));
         want.right_drive = 11'(pid_step(v + turn, sr, 1));
         want.left_speed = 32'(sl);
         want.right_speed = 32'(sr);
         expected_drives.push_back(want);
      endfunction

      function void check_drive(drive_out_type got);
         drive_out_type want;
         faults.delete();
         if (expected_drives.size() == 0) begin
            faults.push_back($sformatf("result %0d %0d %0d %0d with no command outstanding",
               got.left_drive, got.right_drive, got.left_speed, got.right_speed));
            return;
         end
         want = expected_drives.pop_front();
         if (got.left_drive !== want.left_drive)
            faults.push_back($sformatf("left_drive %0d, expected %0d",
               got.left_drive, want.left_drive));
         if (got.right_drive !== want.right_drive)
            faults.push_back($sformatf("right_drive %0d, expected %0d",
               got.right_drive, want.right_drive));
         if (got.left_speed !== want.left_speed)
            faults.push_back($sformatf("left_speed %0d, expected %0d",
               got.left_speed, want.left_speed));
         if (got.right_speed !== want.right_speed)
            faults.push_back($sformatf("right_speed %0d, expected %0d",
               got.right_speed, want.right_speed));
      endfunction

      function int outstanding();
         return expected_drives.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int idle_pct;
   int stall_pct;
   int mismatch_count;
   int quiet_cycles;

   drive_scoreboard sb = new();

   dwsp_req_if req_bus();
   dwsp_rsp_if rsp_bus();

   dual_wheel_speed_pid dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_CAP) begin
         $display("tb: mismatch at %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // both channels are sampled here, ahead of the edge's own updates
   always @(posedge clock) begin : monitor
      wheel_cmd_type c;
      drive_out_type r;
      if (!reset) begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            c.left_count = req_bus.left_count;
            c.right_count = req_bus.right_count;
            c.tick_us = req_bus.tick_us;
            c.target_linear = req_bus.target_linear;
            c.target_angular = req_bus.target_angular;
            sb.note_command(c);
            quiet_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            r.left_drive = rsp_bus.left_drive;
            r.right_drive = rsp_bus.right_drive;
            r.left_speed = rsp_bus.left_speed;
            r.right_speed = rsp_bus.right_speed;
            sb.check_drive(r);
            foreach (sb.faults[k]) report_mismatch(sb.faults[k]);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic wheel_cmd_type make_cmd(input int lc, input int rc, input int tick,
                                              input int v, input int w);
      wheel_cmd_type c;
      c.left_count = 16'(lc);
      c.right_count = 16'(rc);
      c.tick_us = 20'(tick);
      c.target_linear = 21'(v);
      c.target_angular = 22'(w);
      return c;
   endfunction

   function automatic wheel_cmd_type random_command();
      wheel_cmd_type c;
      int lc_pick[5] = '{-32768, 32767, 0, -1, 1};
      int tick_pick[3] = '{0, 1, 'hFFFFF};
      int v_pick[3] = '{-524288, 524288, 0};
      int w_pick[3] = '{-1048576, 1048576, 0};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            // a plausible control tick near 40 Hz
            c = make_cmd(int'($urandom_range(0, 400)) - 200,
                         int'($urandom_range(0, 400)) - 200,
                         $urandom_range(15000, 35000),
                         int'($urandom_range(0, 262144)) - 131072,
                         int'($urandom_range(0, 524288)) - 262144);
         end
         6, 7, 8: begin
            c = make_cmd($urandom, $urandom, $urandom,
                         int'($urandom_range(0, 1048576)) - 524288,
                         int'($urandom_range(0, 2097152)) - 1048576);
         end
         default: begin
            c = make_cmd(lc_pick[$urandom_range(0, 4)], lc_pick[$urandom_range(0, 4)],
                         tick_pick[$urandom_range(0, 2)], v_pick[$urandom_range(0, 2)],
                         w_pick[$urandom_range(0, 2)]);
         end
      endcase
      return c;
   endfunction

   function automatic cfg_type random_config(input bit db_over_limit);
      cfg_type c;
      c.gain_p = 16'($urandom_range(0, $urandom_range(0, 1) ? 65535 : 4095));
      c.gain_d = 16'($urandom_range(0, $urandom_range(0, 1) ? 65535 : 4095));
      c.gain_i = 16'($urandom_range(0, $urandom_range(0, 1) ? 65535 : 1023));
      c.integral_limit = 22'($urandom_range(0, db_over_limit ? 1048576 : 2097152));
      if (db_over_limit) begin
         c.integral_deadband = 22'($urandom_range(c.integral_limit + 1, 2097152));
      end else begin
         c.integral_deadband = 22'($urandom_range(0, 65536));
      end
      c.drive_limit = 10'($urandom);
      c.distance_per_count = 16'($urandom);
      c.half_track = 18'($urandom_range(0, 131072));
      return c;
   endfunction

   task automatic send_command(input wheel_cmd_type c);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.left_count <= c.left_count;
      req_bus.right_count <= c.right_count;
      req_bus.tick_us <= c.tick_us;
      req_bus.target_linear <= c.target_linear;
      req_bus.target_angular <= c.target_angular;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_register(idx, longint'(data));
      @(negedge clock);
   endtask

   task automatic write_config(input cfg_type c);
      write_csr(CSR_GAIN_P, CSR_DATA_W'(c.gain_p));
      write_csr(CSR_GAIN_D, CSR_DATA_W'(c.gain_d));
      write_csr(CSR_GAIN_I, CSR_DATA_W'(c.gain_i));
      write_csr(CSR_INTEGRAL_LIMIT, CSR_DATA_W'(c.integral_limit));
      write_csr(CSR_INTEGRAL_DEADBAND, CSR_DATA_W'(c.integral_deadband));
      write_csr(CSR_DRIVE_LIMIT, CSR_DATA_W'(c.drive_limit));
      write_csr(CSR_DISTANCE_PER_COUNT, CSR_DATA_W'(c.distance_per_count));
      write_csr(CSR_HALF_TRACK, CSR_DATA_W'(c.half_track));
      csr_wr_en <= 1'b0;
   endtask

   // wait for every outstanding transaction, then let the pipeline go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (sb.outstanding() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      cfg_type cfg;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_GAIN_P;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.left_count = '0;
      req_bus.right_count = '0;
      req_bus.tick_us = '0;
      req_bus.target_linear = '0;
      req_bus.target_angular = '0;
      rsp_bus.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero tick length, then speeds saturating both ways
      send_command(make_cmd(0, 0, 0, 0, 0));
      send_command(make_cmd(32767, -32768, 1, 0, 0));
      // errors beyond the 32-bit range, high then low
      send_command(make_cmd(-32768, 32767, 1, 524288, -1048576));
      send_command(make_cmd(32767, -32768, 1, -524288, 1048576));
      send_command(make_cmd(32767, -32768, 'hFFFFF, 524288, 1048576));
      send_command(make_cmd(1, -1, 'hFFFFF, 0, 0));
      send_command(make_cmd(-1, 1, 1, -524288, -1048576));
      repeat (3) send_command(make_cmd(100, 120, 25000, 32768, 16384));
      send_command(make_cmd(-150, -90, 24000, -65536, -32768));

      // measured speeds and turn read zero, so the integral tracks the linear target
      settle();
      cfg = DEFAULT_CFG;
      cfg.distance_per_count = '0;
      cfg.half_track = '0;
      write_config(cfg);
      send_command(make_cmd(40, -40, 25000, 9830, 300000));
      send_command(make_cmd(-40, 40, 25000, -19660, -300000));
      send_command(make_cmd(7, 7, 25000, 9829, 0));
      send_command(make_cmd(0, 0, 25000, -9829, 0));

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settle();
         case (ph)
            0: cfg = DEFAULT_CFG;
            1: cfg = MAX_CFG;
            2: cfg = '0;
            default: cfg = random_config(ph == 3);
         endcase
         write_config(cfg);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         repeat (RANDOM_PER_PHASE) send_command(random_command());
      end

      settle();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
